// ===== rtl/pbrle_pkg.sv =====
// ----------------------------------------------------------------------------
// pbrle_pkg
// shared widths, header constants and sequencer state codes for the
// packbits style rle decoder
// ----------------------------------------------------------------------------
package pbrle_pkg;

    localparam int BYTE_W         = 8;
    localparam int MAX_LANES      = 8;
    localparam int OUT_W          = BYTE_W * MAX_LANES;
    localparam int COUNT_W        = 4;
    localparam int LEN_W          = 7;
    localparam int RUN_W          = 8;
    localparam int LANE_BYTES_DEF = 8;

    localparam int          HDR_RUN_BIT  = 7;
    localparam logic [6:0]  HDR_LEN_MASK = 7'h7f;

    typedef enum logic [3:0] {
        ST_HEADER = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_RAW    = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

endpackage

// ===== rtl/packbits_style_rle_decoder_core.sv =====
// ----------------------------------------------------------------------------
// packbits_style_rle_decoder_core
// decodes a packbits / tga style rle byte stream into words of up to
// eight byte lanes with a byte count and a last-of-item flag
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid, in_stall, in_byte               | into core
//  output  | out_valid, out_stall, out_bytes,          | out of core
//          | byte_count, last_of_item                  |
//
//  header and literal bytes are each taken in one transfer; a literal transfer needs the
//  output register free or draining in the same cycle
//  a run value byte is followed by ceil(run / lanes) chunks, run being 1 to 128:
//  one shared subtract and compare unit cuts one chunk per cycle while the
//  output is not stalled, and input is stalled meanwhile
//  output stall holds the output register and, through it, the input side
//  reset (rst_n low, asynchronous) returns to expecting a header byte
// ----------------------------------------------------------------------------
module packbits_style_rle_decoder_core
    import pbrle_pkg::*;
#(
    parameter int LANE_BYTES = LANE_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   in_byte,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [OUT_W-1:0]    out_bytes,
    output logic [COUNT_W-1:0]  byte_count,
    output logic                last_of_item
);

    // lane count clamped to what the output word holds
    localparam int LANES = (LANE_BYTES < 1) ? 1 :
                           ((LANE_BYTES > MAX_LANES) ? MAX_LANES : LANE_BYTES);

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    remaining_reg, remaining_next;
    logic [RUN_W-1:0]    run_left_reg, run_left_next;
    logic [BYTE_W-1:0]   value_reg, value_next;

    logic                out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]    out_bytes_reg, out_bytes_next;
    logic [COUNT_W-1:0]  byte_count_reg, byte_count_next;
    logic                last_reg, last_next;

    logic                out_free;
    logic                in_xfer;
    logic [COUNT_W-1:0]  chunk;
    logic [OUT_W-1:0]    chunk_word;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg == ST_EMIT) || !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // shared chunk unit: size of the next piece of the run
    assign chunk = (run_left_reg < RUN_W'(LANES)) ? run_left_reg[COUNT_W-1:0]
                                                  : COUNT_W'(LANES);

    always_comb
    begin
        for (int i = 0; i < MAX_LANES; i++)
        begin
            chunk_word[i*BYTE_W +: BYTE_W] =
                (COUNT_W'(i) < chunk) ? value_reg : '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        remaining_next  = remaining_reg;
        run_left_next   = run_left_reg;
        value_next      = value_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_bytes_next  = out_bytes_reg;
        byte_count_next = byte_count_reg;
        last_next       = last_reg;

        case (state_reg)
            ST_HEADER:
            begin
                if (in_xfer)
                begin
                    if (in_byte[HDR_RUN_BIT])
                    begin
                        run_left_next = {1'b0, in_byte[LEN_W-1:0] & HDR_LEN_MASK}
                                        + RUN_W'(1);
                        state_next    = ST_RUN;
                    end
                    else
                    begin
                        remaining_next = in_byte[LEN_W-1:0] & HDR_LEN_MASK;
                        state_next     = ST_RAW;
                    end
                end
            end
            ST_RUN:
            begin
                if (in_xfer)
                begin
                    value_next = in_byte;
                    state_next = ST_EMIT;
                end
            end
            ST_RAW:
            begin
                if (in_xfer)
                begin
                    out_valid_next  = 1'b1;
                    out_bytes_next  = {{(OUT_W-BYTE_W){1'b0}}, in_byte};
                    byte_count_next = COUNT_W'(1);
                    last_next       = 1'b1;
                    if (remaining_reg == '0)
                        state_next = ST_HEADER;
                    else
                        remaining_next = remaining_reg - LEN_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bytes_next  = chunk_word;
                    byte_count_next = chunk;
                    last_next       = (run_left_reg == RUN_W'(chunk));
                    run_left_next   = run_left_reg - RUN_W'(chunk);
                    if (run_left_reg == RUN_W'(chunk))
                        state_next = ST_HEADER;
                end
            end
            default:
            begin
                state_next = ST_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HEADER;
            remaining_reg <= '0;
            run_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            run_left_reg  <= run_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg      <= value_next;
        out_bytes_reg  <= out_bytes_next;
        byte_count_reg <= byte_count_next;
        last_reg       <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_bytes    = out_bytes_reg;
    assign byte_count   = byte_count_reg;
    assign last_of_item = last_reg;

    // a shown result always carries between one and the lane count of bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count != '0) && (byte_count <= COUNT_W'(LANES)))
        else $error("byte count out of range");

    // chunking never starts on an empty run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (run_left_reg != '0))
        else $error("run chunking with nothing left");

    // a chunk that is not the last leaves the sequencer still cutting the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_of_item) |-> (state_reg == ST_EMIT))
        else $error("run ended without a last chunk");

endmodule
